FILE: sv/palette_fade_engine_assert.svh
// Assertion helpers for the palette fade engine.
// Both sample on clk and are disabled while arst_n is low.
`ifndef PALETTE_FADE_ENGINE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define PFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

	localparam int NUM_PAL  = 3;
	localparam int SHADE_W  = 2;
	localparam int NUM_SHD  = 4;
	localparam int PAL_W    = SHADE_W * NUM_SHD;
	localparam int TICK_W   = 8;
	localparam int SEL_W    = 2;

	// Input tdata: fade_mask, shade_value, step_interval, palette_select
	localparam int IN_DATA_W  = 24;
	// Output tdata: three palettes, then fading_mask
	localparam int OUT_DATA_W = 32;

	typedef logic [PAL_W-1:0]   pal_t;
	typedef logic [NUM_PAL-1:0] pmask_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_SET   = 2'd2
	} cmd_t;

endpackage

FILE: sv/pfe_pal_step.sv
`timescale 1ns / 1ps

// One fade step of a palette: each shade moves one count toward its goal.
module pfe_pal_step (
	input  pfe_pkg::pal_t cur,
	input  pfe_pkg::pal_t goal,
	output pfe_pkg::pal_t nxt,
	output logic          matched
);
	import pfe_pkg::*;

	logic [NUM_SHD-1:0] shd_eq;

	// Per-shade compare and step
	always_comb begin
		logic [SHADE_W-1:0] s;
		logic [SHADE_W-1:0] g;
		nxt    = '0;
		shd_eq = '0;
		for (int k = 0; k < NUM_SHD; k++) begin
			s = cur[k*SHADE_W +: SHADE_W];
			g = goal[k*SHADE_W +: SHADE_W];
			if (s == g) begin
				shd_eq[k] = 1'b1;
			end else if (s < g) begin
				s = s + 1'b1;
			end else begin
				s = s - 1'b1;
			end
			nxt[k*SHADE_W +: SHADE_W] = s;
		end
	end

	// Palette is done only if every shade already matched
	assign matched = &shd_eq;

endmodule

FILE: sv/palette_fade_engine.sv
`timescale 1ns / 1ps

// A beat accepted into the input register passes through the state-update stage into
// the result register. Throughput: one beat per cycle while m_tready does not stall the
// result register; the single state-update stage sets this figure.
// Reset (arst_n low, asynchronous): palettes, goals, timer, interval and fading
// mask clear to zero; both register stages go empty.
module palette_fade_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] fade_mask, [10:3] shade_value, [18:11] step_interval,
	// [20:19] palette_select, [23:21] zero
	input  logic [pfe_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] command
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] background_palette, [15:8] sprite0_palette, [23:16] sprite1_palette,
	// [26:24] fading_mask, [31:27] zero
	output logic [pfe_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import pfe_pkg::*;

	`include "palette_fade_engine_assert.svh"

	// Input register
	logic               vld_s1;
	cmd_t               cmd_s1;
	pmask_t             mask_s1;
	pal_t               shade_s1;
	logic [TICK_W-1:0]  intv_s1;
	logic [SEL_W-1:0]   sel_s1;

	// State
	pmask_t             act_q;
	logic [TICK_W-1:0]  tick_q;
	logic [TICK_W-1:0]  intv_q;
	pal_t               goal_q [NUM_PAL];
	pal_t               live_q [NUM_PAL];

	// Result register
	logic               out_vld_q;
	pal_t               out_pal_q [NUM_PAL];
	pmask_t             out_mask_q;

	logic               advance;
	logic               take_s1;

	assign advance  = !out_vld_q || m_tready;
	assign take_s1  = vld_s1 && advance;
	assign s_tready = !vld_s1 || advance;

	// Capture input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= cmd_t'(s_tuser);
			mask_s1  <= s_tdata[2:0];
			shade_s1 <= s_tdata[10:3];
			intv_s1  <= s_tdata[18:11];
			sel_s1   <= s_tdata[20:19];
		end
	end

	// Fade step for each palette
	pal_t   step_pal [NUM_PAL];
	pmask_t step_done;

	for (genvar p = 0; p < NUM_PAL; p++) begin : g_step
		pfe_pal_step u_step (
			.cur     (live_q[p]),
			.goal    (goal_q[p]),
			.nxt     (step_pal[p]),
			.matched (step_done[p])
		);
	end

	// Next state for the beat in stage 1
	logic [TICK_W-1:0] tick_inc;
	logic              step_now;
	pmask_t            act_d;
	logic [TICK_W-1:0] tick_d;
	logic [TICK_W-1:0] intv_d;
	pal_t              goal_d [NUM_PAL];
	pal_t              live_d [NUM_PAL];

	assign tick_inc = tick_q + 1'b1;

	always_comb begin
		act_d    = act_q;
		tick_d   = tick_q;
		intv_d   = intv_q;
		step_now = 1'b0;
		for (int p = 0; p < NUM_PAL; p++) begin
			goal_d[p] = goal_q[p];
			live_d[p] = live_q[p];
		end
		case (cmd_s1)
			CMD_TICK: begin
				if (act_q != '0) begin
					if (tick_inc == intv_q) begin
						tick_d   = '0;
						step_now = 1'b1;
					end else begin
						tick_d = tick_inc;
					end
				end
				if (step_now) begin
					for (int p = 0; p < NUM_PAL; p++) begin
						if (act_q[p]) begin
							live_d[p] = step_pal[p];
						end
					end
					act_d = act_q & ~step_done;
				end
			end
			CMD_START: begin
				act_d  = act_q | mask_s1;
				tick_d = '0;
				intv_d = intv_s1;
				for (int p = 0; p < NUM_PAL; p++) begin
					if (mask_s1[p]) begin
						goal_d[p] = shade_s1;
					end
				end
			end
			CMD_SET: begin
				// A select past the last palette matches nothing
				for (int p = 0; p < NUM_PAL; p++) begin
					if (sel_s1 == SEL_W'(p)) begin
						live_d[p] = shade_s1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// State update and result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= '0;
			tick_q    <= '0;
			intv_q    <= '0;
			out_vld_q <= 1'b0;
			for (int p = 0; p < NUM_PAL; p++) begin
				goal_q[p] <= '0;
				live_q[p] <= '0;
			end
		end else begin
			if (advance) begin
				out_vld_q <= vld_s1;
			end
			if (take_s1) begin
				act_q  <= act_d;
				tick_q <= tick_d;
				intv_q <= intv_d;
				for (int p = 0; p < NUM_PAL; p++) begin
					goal_q[p] <= goal_d[p];
					live_q[p] <= live_d[p];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			out_mask_q <= act_d;
			for (int p = 0; p < NUM_PAL; p++) begin
				out_pal_q[p] <= live_d[p];
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, out_mask_q, out_pal_q[2], out_pal_q[1], out_pal_q[0]};

	// Checks
	`PFE_ASSERT_NEXT(a_act_set_only_start, take_s1 && cmd_s1 != CMD_START,
		(act_q & ~$past(act_q)) == '0, "fading bit set without a start")
	`PFE_ASSERT_NEXT(a_idle_timer_holds, take_s1 && cmd_s1 == CMD_TICK && act_q == '0,
		tick_q == $past(tick_q), "timer moved with nothing fading")
	`PFE_ASSERT_NOW(a_out_mask_tracks, out_vld_q,
		out_mask_q == act_q, "reported fading mask differs from state")
	`PFE_ASSERT_NEXT(a_s1_holds, vld_s1 && !advance,
		vld_s1 && $stable(cmd_s1), "stage 1 beat lost while stalled")

endmodule

FILE: sim/tb_palette_fade_engine.sv
`timescale 1ns / 1ps

module tb_palette_fade_engine;

	import pfe_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int CYCLE_CAP  = 600000;
	localparam int PHASE_BEATS = 470;

	// command 3 is not decoded by the block
	localparam logic [1:0] CMD_NONE = 2'd3;

	// palette indexes, also the set-command selector values
	localparam logic [1:0] SEL_BG   = 2'd0;
	localparam logic [1:0] SEL_SP0  = 2'd1;
	localparam logic [1:0] SEL_SP1  = 2'd2;
	localparam logic [1:0] SEL_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]      op;
		pmask_t          mask;
		pal_t            shade;
		logic [TICK_W-1:0] gap;
		logic [SEL_W-1:0]  sel;
	} fade_cmd_t;

	typedef struct packed {
		pal_t   bg;
		pal_t   sp0;
		pal_t   sp1;
		pmask_t fading;
	} palette_view_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	palette_fade_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predicted block state
	pmask_t            fading_set;
	logic [TICK_W-1:0] tick_timer;
	logic [TICK_W-1:0] step_gap;
	pal_t              goal_pal [NUM_PAL];
	pal_t              live_pal [NUM_PAL];

	fade_cmd_t     pending_cmds [$];
	palette_view_t palette_views_due [$];
	fade_cmd_t     cmd_on_bus;
	palette_view_t want;

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int cycle_count;

	task automatic flag_error(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	// one fade step on palette p; drops it from the fading set once it matched
	task automatic step_palette(input int p);
		pal_t       nxt;
		logic [1:0] cur_s;
		logic [1:0] goal_s;
		int         hits;
		nxt  = '0;
		hits = 0;
		for (int k = 0; k < NUM_SHD; k++) begin
			cur_s  = live_pal[p][SHADE_W*k +: SHADE_W];
			goal_s = goal_pal[p][SHADE_W*k +: SHADE_W];
			if (cur_s == goal_s)
				hits++;
			else if (cur_s < goal_s)
				cur_s = cur_s + 2'd1;
			else
				cur_s = cur_s - 2'd1;
			nxt[SHADE_W*k +: SHADE_W] = cur_s;
		end
		live_pal[p] = nxt;
		if (hits == NUM_SHD)
			fading_set[p] = 1'b0;
	endtask

	// apply one accepted command and queue the palettes it should produce
	task automatic advance_palettes(input fade_cmd_t c);
		palette_view_t v;
		case (c.op)
			CMD_TICK: begin
				if (fading_set != '0) begin
					tick_timer = tick_timer + 8'd1;
					if (tick_timer == step_gap) begin
						tick_timer = '0;
						for (int p = 0; p < NUM_PAL; p++)
							if (fading_set[p])
								step_palette(p);
					end
				end
			end
			CMD_START: begin
				fading_set = fading_set | c.mask;
				tick_timer = '0;
				step_gap   = c.gap;
				for (int p = 0; p < NUM_PAL; p++)
					if (c.mask[p])
						goal_pal[p] = c.shade;
			end
			CMD_SET: begin
				if (c.sel != SEL_NONE)
					live_pal[c.sel] = c.shade;
			end
			default: ;
		endcase
		v.bg     = live_pal[SEL_BG];
		v.sp0    = live_pal[SEL_SP0];
		v.sp1    = live_pal[SEL_SP1];
		v.fading = fading_set;
		palette_views_due.push_back(v);
	endtask

	task automatic push_cmd(input logic [1:0] op, input pmask_t mask, input pal_t shade,
			input logic [TICK_W-1:0] gap, input logic [SEL_W-1:0] sel);
		fade_cmd_t c;
		c.op    = op;
		c.mask  = mask;
		c.shade = shade;
		c.gap   = gap;
		c.sel   = sel;
		pending_cmds.push_back(c);
	endtask

	// start a fade, then mostly ticks with the odd overwrite or restart mixed in
	task automatic queue_fade_run(output int n);
		logic [TICK_W-1:0] gap;
		pmask_t            mask;
		int                r;
		int                ticks;
		r = $urandom_range(99);
		if (r < 70)
			gap = 8'($urandom_range(1, 3));
		else if (r < 90)
			gap = 8'($urandom_range(4, 10));
		else
			gap = 8'($urandom_range(11, 255));
		mask = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
		push_cmd(CMD_START, mask, 8'($urandom), gap, 2'($urandom));
		n = 1;
		ticks = int'(gap) * $urandom_range(2, 6);
		if (ticks > 48)
			ticks = 48;
		for (int i = 0; i < ticks; i++) begin
			r = $urandom_range(99);
			if (r < 8)
				push_cmd(CMD_SET, 3'($urandom), 8'($urandom), 8'($urandom),
					2'($urandom_range(0, 2)));
			else if (r < 11)
				push_cmd(CMD_START, 3'($urandom), 8'($urandom), gap, 2'($urandom));
			else
				push_cmd(CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
			n++;
		end
	endtask

	task automatic queue_phase(input int beats, input bit with_slow_step);
		int made;
		int n;
		int r;
		made = 0;
		// interval 0: one step only after 256 ticks
		if (with_slow_step) begin
			push_cmd(CMD_START, 3'($urandom_range(1, 7)), 8'($urandom), 8'd0, 2'($urandom));
			repeat (260)
				push_cmd(CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
			made = 261;
		end
		while (made < beats) begin
			r = $urandom_range(99);
			if (r < 60) begin
				queue_fade_run(n);
				made += n;
			end else if (r < 92) begin
				push_cmd(2'($urandom_range(0, 2)), 3'($urandom), 8'($urandom), 8'($urandom),
					2'($urandom_range(0, 2)));
				made++;
			end else if (r < 96) begin
				push_cmd(CMD_NONE, 3'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
				made++;
			end else begin
				push_cmd(CMD_SET, 3'($urandom), 8'($urandom), 8'($urandom), SEL_NONE);
				made++;
			end
		end
	endtask

	task automatic drain;
		while (pending_cmds.size() != 0 || s_tvalid || palette_views_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// slave side: launch queued commands, predict on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				advance_palettes(cmd_on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_on_bus = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, cmd_on_bus.sel, cmd_on_bus.gap, cmd_on_bus.shade,
						cmd_on_bus.mask};
					s_tuser  <= cmd_on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// master side: random backpressure, compare each result beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (palette_views_due.size() == 0) begin
					flag_error($sformatf("result beat %h with none pending", m_tdata));
				end else begin
					want = palette_views_due.pop_front();
					if (m_tdata[7:0] !== want.bg)
						flag_error($sformatf("background %h, want %h", m_tdata[7:0], want.bg));
					if (m_tdata[15:8] !== want.sp0)
						flag_error($sformatf("sprite0 %h, want %h", m_tdata[15:8], want.sp0));
					if (m_tdata[23:16] !== want.sp1)
						flag_error($sformatf("sprite1 %h, want %h", m_tdata[23:16], want.sp1));
					if (m_tdata[26:24] !== want.fading)
						flag_error($sformatf("fading mask %b, want %b", m_tdata[26:24],
							want.fading));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_CAP) begin
			$display("tb_palette_fade_engine: errors");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		cycle_count    = 0;
		fading_set     = '0;
		tick_timer     = '0;
		step_gap       = '0;
		for (int p = 0; p < NUM_PAL; p++) begin
			goal_pal[p] = '0;
			live_pal[p] = '0;
		end

		// directed: idle tick, direct writes, ignored commands, empty start
		push_cmd(CMD_TICK,  3'd7, 8'hFF, 8'hFF, SEL_SP1);
		push_cmd(CMD_SET,   3'd0, 8'hFF, 8'h00, SEL_BG);
		push_cmd(CMD_SET,   3'd7, 8'h00, 8'hFF, SEL_SP0);
		push_cmd(CMD_SET,   3'd2, 8'hE4, 8'h5A, SEL_SP1);
		push_cmd(CMD_SET,   3'd5, 8'h55, 8'hA5, SEL_NONE);
		push_cmd(CMD_NONE,  3'd7, 8'hFF, 8'hFF, SEL_NONE);
		push_cmd(CMD_START, 3'd0, 8'hAA, 8'hFF, SEL_BG);
		// fade all three, one step per tick, through to the matched drop-out
		push_cmd(CMD_START, 3'd7, 8'h1B, 8'h01, SEL_BG);
		repeat (5)
			push_cmd(CMD_TICK, 3'd0, 8'h00, 8'h00, SEL_BG);
		// overwrite a palette in the middle of its fade
		push_cmd(CMD_START, 3'd1, 8'h00, 8'h02, SEL_BG);
		repeat (2)
			push_cmd(CMD_TICK, 3'd0, 8'h00, 8'h00, SEL_BG);
		push_cmd(CMD_SET,   3'd0, 8'hFF, 8'h00, SEL_BG);
		repeat (6)
			push_cmd(CMD_TICK, 3'd0, 8'h00, 8'h00, SEL_BG);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		drain;

		queue_phase(PHASE_BEATS, 1'b1);
		drain;

		send_idle_pct  = 80;
		recv_stall_pct = 0;
		queue_phase(PHASE_BEATS, 1'b0);
		drain;

		send_idle_pct  = 0;
		recv_stall_pct = 80;
		queue_phase(PHASE_BEATS, 1'b0);
		drain;

		send_idle_pct  = 33;
		recv_stall_pct = 33;
		queue_phase(PHASE_BEATS, 1'b0);
		drain;

		// let any stray beats surface
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb_palette_fade_engine: clean");
		else
			$display("tb_palette_fade_engine: errors");
		$finish;
	end

endmodule
